@@ sv/token_length_and_char_histogram_macros.svh @@
// ----------------------------------------------------------------------------
// token length and character histogram: assertion macros
// shared property wrappers on clk with rst_n as the disable condition
// ----------------------------------------------------------------------------
`ifndef TOKEN_LENGTH_AND_CHAR_HISTOGRAM_MACROS_SVH
`define TOKEN_LENGTH_AND_CHAR_HISTOGRAM_MACROS_SVH

// expression holds at every clock edge out of reset
`define TLCH_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tlch: invariant violated");

// consequent holds in the cycle after the antecedent
`define TLCH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlch: next-cycle check failed");

`endif

@@ sv/tlch_pkg.sv @@
// ----------------------------------------------------------------------------
// tlch_pkg
// types, command codes and the separator test for the token histogram
// ----------------------------------------------------------------------------
package tlch_pkg;

    localparam int IDX_W       = 7;
    localparam int BYTE_W      = 8;
    localparam int CMD_W       = 2;
    localparam int RESULT_W    = 32;
    localparam int CHAR_CODES  = 128;
    localparam int QUEUE_DEPTH = 2;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    // command codes
    localparam logic [CMD_W-1:0] CMD_DATA      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FLUSH     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_LEN  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ_CHAR = 2'd3;

    // work handed from the front end to the back end
    typedef enum logic [2:0] {
        OP_BUMP_LEN,
        OP_BUMP_CHAR,
        OP_READ_LEN,
        OP_READ_CHAR,
        OP_READ_ZERO
    } op_kind_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] byte_value;
        logic [IDX_W-1:0]  bin_index;
    } item_t;

    typedef struct packed {
        logic [RESULT_W-1:0] count;
        logic [IDX_W-1:0]    index_echo;
    } result_t;

    typedef struct packed {
        op_kind_t         kind;
        logic [IDX_W-1:0] index;
    } op_t;

    typedef struct packed {
        logic [QC_W-1:0] count;
        logic            full;
        logic            empty;
    } queue_status_t;

    // token separators, nul included
    function automatic logic is_separator(input logic [BYTE_W-1:0] b);
        logic sep;
        case (b) inside
            8'h00,          // nul
            8'h7B, 8'h7D,   // braces
            8'h28, 8'h29,   // parentheses
            8'h5B, 8'h5D,   // brackets
            8'h2C, 8'h3B,   // comma, semicolon
            8'h22,          // double quote
            8'h20, 8'h0A,   // space, newline
            8'h09, 8'h5E:   // tab, caret
                sep = 1'b1;
            default:
                sep = 1'b0;
        endcase
        return sep;
    endfunction

endpackage

@@ sv/tlch_front.sv @@
// ----------------------------------------------------------------------------
// tlch_front
// accepts items, tracks the pending token, emits at most one counter op each
// ----------------------------------------------------------------------------
module tlch_front #(
    parameter int LENGTH_BINS = 30
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  tlch_pkg::item_t         item,
    input  tlch_pkg::queue_status_t q_status,
    output logic                    push,
    output tlch_pkg::op_t           push_op
);
    import tlch_pkg::*;

    localparam int TL_W = $clog2(LENGTH_BINS + 1);

    logic [TL_W-1:0] tok_len_reg;
    logic [TL_W-1:0] tok_len_next;
    logic            accept;
    logic            pending;
    logic            op_valid;
    op_t             op;

    assign item_ready = !q_status.full;
    assign accept     = item_valid && item_ready;
    assign pending    = (tok_len_reg != '0);

    // classify the transaction
    always_comb
    begin
        tok_len_next = tok_len_reg;
        op_valid     = 1'b0;
        op.kind      = OP_READ_ZERO;
        op.index     = item.bin_index;
        case (item.command)
            CMD_DATA:
            begin
                if (is_separator(item.byte_value))
                begin
                    if (pending)
                    begin
                        op_valid     = 1'b1;
                        op.kind      = OP_BUMP_LEN;
                        op.index     = IDX_W'(tok_len_reg - 1'b1);
                        tok_len_next = '0;
                    end
                end
                else
                begin
                    if (tok_len_reg < TL_W'(LENGTH_BINS))
                        tok_len_next = tok_len_reg + 1'b1;
                    if (item.byte_value inside {[8'd2:8'd127]})
                    begin
                        op_valid = 1'b1;
                        op.kind  = OP_BUMP_CHAR;
                        op.index = item.byte_value[IDX_W-1:0];
                    end
                end
            end
            CMD_FLUSH:
            begin
                if (pending)
                begin
                    op_valid     = 1'b1;
                    op.kind      = OP_BUMP_LEN;
                    op.index     = IDX_W'(tok_len_reg - 1'b1);
                    tok_len_next = '0;
                end
            end
            CMD_READ_LEN:
            begin
                op_valid = 1'b1;
                op.kind  = (item.bin_index < IDX_W'(LENGTH_BINS)) ? OP_READ_LEN : OP_READ_ZERO;
            end
            CMD_READ_CHAR:
            begin
                op_valid = 1'b1;
                op.kind  = OP_READ_CHAR;
            end
            default:
            begin
                op_valid = 1'b0;
            end
        endcase
    end

    // pending token length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_len_reg <= '0;
        else if (accept)
            tok_len_reg <= tok_len_next;
    end

    assign push    = accept && op_valid;
    assign push_op = op;

endmodule

@@ sv/tlch_queue.sv @@
// ----------------------------------------------------------------------------
// tlch_queue
// short op queue between the front end and the back end
// ----------------------------------------------------------------------------
module tlch_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tlch_pkg::op_t           push_op,
    input  logic                    pop,
    output tlch_pkg::op_t           head,
    output tlch_pkg::queue_status_t status
);
    import tlch_pkg::*;

    op_t             entry_reg [QUEUE_DEPTH];
    logic [QA_W-1:0] wr_ptr_reg;
    logic [QA_W-1:0] rd_ptr_reg;
    logic [QC_W-1:0] count_reg;
    logic [QC_W-1:0] count_next;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= QA_W'(wr_ptr_reg + 1'b1);
            if (pop)
                rd_ptr_reg <= QA_W'(rd_ptr_reg + 1'b1);
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.full  = (count_reg == QC_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

@@ sv/tlch_back.sv @@
// ----------------------------------------------------------------------------
// tlch_back
// counter memories with forwarded read-modify-write and the result register
// ----------------------------------------------------------------------------
module tlch_back #(
    parameter int LENGTH_BINS = 30,
    parameter int COUNT_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  tlch_pkg::op_t     head,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_ready,
    output tlch_pkg::result_t result
);
    import tlch_pkg::*;

    localparam int LA_W = (LENGTH_BINS > 1) ? $clog2(LENGTH_BINS) : 1;

    // counter stores
    logic [COUNT_WIDTH-1:0] len_mem  [LENGTH_BINS];
    logic [COUNT_WIDTH-1:0] char_mem [CHAR_CODES];
    logic [COUNT_WIDTH-1:0] len_rd_reg;
    logic [COUNT_WIDTH-1:0] char_rd_reg;
    logic [LENGTH_BINS-1:0] len_vld_reg;
    logic [CHAR_CODES-1:0]  char_vld_reg;

    // update stage
    logic                   b_valid_reg;
    op_t                    b_op_reg;

    // last write, for forwarding
    logic                   lw_valid_reg;
    logic                   lw_char_reg;
    logic [IDX_W-1:0]       lw_index_reg;
    logic [COUNT_WIDTH-1:0] lw_data_reg;

    // result register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_t                out_reg;

    logic                   head_is_char;
    logic                   head_is_len;
    logic [LA_W-1:0]        head_la;
    logic                   b_is_read;
    logic                   b_is_char;
    logic [LA_W-1:0]        b_la;
    logic                   fwd_hit;
    logic [COUNT_WIDTH-1:0] stored_val;
    logic [COUNT_WIDTH-1:0] cur_val;
    logic [COUNT_WIDTH-1:0] new_val;
    logic [COUNT_WIDTH+RESULT_W-1:0] cur_wide;
    logic                   out_free;
    logic                   adv;
    logic                   bump_wr;
    logic                   out_load;

    assign head_is_char = (head.kind == OP_BUMP_CHAR) || (head.kind == OP_READ_CHAR);
    assign head_is_len  = (head.kind == OP_BUMP_LEN) || (head.kind == OP_READ_LEN);
    assign head_la      = head.index[LA_W-1:0];

    assign b_is_read = (b_op_reg.kind == OP_READ_LEN) || (b_op_reg.kind == OP_READ_CHAR) ||
                       (b_op_reg.kind == OP_READ_ZERO);
    assign b_is_char = (b_op_reg.kind == OP_BUMP_CHAR) || (b_op_reg.kind == OP_READ_CHAR);
    assign b_la      = b_op_reg.index[LA_W-1:0];

    // stall only when a read result has nowhere to go
    assign out_free = !out_valid_reg || result_ready;
    assign adv      = !b_valid_reg || !b_is_read || out_free;
    assign pop      = adv && head_valid;
    assign bump_wr  = b_valid_reg && !b_is_read;
    assign out_load = b_valid_reg && b_is_read && out_free;

    // current counter value: forwarded, stored or cleared
    always_comb
    begin
        if (b_is_char)
            stored_val = char_vld_reg[b_op_reg.index] ? char_rd_reg : '0;
        else
            stored_val = len_vld_reg[b_la] ? len_rd_reg : '0;
        fwd_hit = lw_valid_reg && (lw_char_reg == b_is_char) && (lw_index_reg == b_op_reg.index);
        cur_val = fwd_hit ? lw_data_reg : stored_val;
        new_val = (&cur_val) ? cur_val : cur_val + 1'b1;
        cur_wide = {{RESULT_W{1'b0}}, cur_val};
    end

    // memory writes and registered reads
    always_ff @(posedge clk)
    begin
        if (bump_wr && b_is_char)
            char_mem[b_op_reg.index] <= new_val;
        if (bump_wr && !b_is_char)
            len_mem[b_la] <= new_val;
        if (pop && head_is_char)
            char_rd_reg <= char_mem[head.index];
        if (pop && head_is_len)
            len_rd_reg <= len_mem[head_la];
    end

    // valid bits and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_vld_reg   <= '0;
            char_vld_reg  <= '0;
            b_valid_reg   <= 1'b0;
            lw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (bump_wr && b_is_char)
                char_vld_reg[b_op_reg.index] <= 1'b1;
            if (bump_wr && !b_is_char)
                len_vld_reg[b_la] <= 1'b1;
            if (adv)
                b_valid_reg <= head_valid;
            if (bump_wr)
                lw_valid_reg <= 1'b1;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
            b_op_reg <= head;
        if (bump_wr)
        begin
            lw_char_reg  <= b_is_char;
            lw_index_reg <= b_op_reg.index;
            lw_data_reg  <= new_val;
        end
        if (out_load)
        begin
            out_reg.count      <= (b_op_reg.kind == OP_READ_ZERO) ? '0 : cur_wide[RESULT_W-1:0];
            out_reg.index_echo <= b_op_reg.index;
        end
    end

    // result handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ sv/token_length_and_char_histogram.sv @@
// ----------------------------------------------------------------------------
// token_length_and_char_histogram
// text stream tokeniser with token length and character frequency counters
// ----------------------------------------------------------------------------
// Takes one transaction per clock while results are taken: data bytes, flush
// and both read commands alike. A read result reaches result_valid through
// the op queue, the back end's update stage and the result register; that stage
// holds the registered read of the counter memories in the read-modify-write,
// with the last write forwarded so that back-to-back updates of one counter
// stay exact. A two-entry op queue separates the tokeniser from the counter
// update, so a stalled result holds the back end while input is still taken
// until the queue fills. Counters come out of reset cleared at once (per-entry
// valid bits), with no clearing pass.
`include "token_length_and_char_histogram_macros.svh"

module token_length_and_char_histogram #(
    parameter int LENGTH_BINS = 30,
    parameter int COUNT_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  tlch_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output tlch_pkg::result_t result
);
    import tlch_pkg::*;

    logic          push;
    op_t           push_op;
    logic          pop;
    op_t           head;
    queue_status_t q_status;

    // tokeniser and classifier
    tlch_front #(
        .LENGTH_BINS (LENGTH_BINS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_status   (q_status),
        .push       (push),
        .push_op    (push_op)
    );

    // op queue
    tlch_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .status  (q_status)
    );

    // counter update and read
    tlch_back #(
        .LENGTH_BINS (LENGTH_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (!q_status.empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // checks
    `TLCH_ASSERT_ALWAYS(a_full_blocks_input, !(q_status.full && item_ready))
    `TLCH_ASSERT_ALWAYS(a_pop_needs_entry, !(pop && q_status.empty))
    `TLCH_ASSERT_NEXT(a_fill_to_full, push && !pop && (q_status.count == QC_W'(QUEUE_DEPTH - 1)), q_status.full)

endmodule
